// ===== src/shbr_pkg.sv =====
// Shared types and constants for the stream half-buffer refill controller.
// Used by every module of the block; depends on nothing.
package shbr_pkg;

    // Default values for the top-level parameters
    localparam int STREAMS_DEF         = 16;
    localparam int RING_SAMPLES_DEF    = 32768;
    localparam int READ_BYTES_MONO_DEF = 8192;

    // Stream bus widths (tdata padded to whole bytes)
    localparam int IN_DATA_W  = 104;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 80;

    // Item kinds carried on s_tuser
    localparam logic [1:0] KIND_POLL  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_STOP  = 2'd2;

    // Fields of one input transaction
    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  stream_index;
        logic [15:0] left_pos;
        logic [31:0] left_version;
        logic [23:0] total_samples_in;
        logic        loop_in;
        logic        stereo_in;
        logic [24:0] start_offset;
    } item_t;

    // Per-stream context
    typedef struct packed {
        logic        active;
        logic [24:0] played;
        logic [23:0] total;
        logic [24:0] byte_offset;
        logic        upper_next;
        logic        first_pending;
        logic        loops;
        logic        two_channel;
        logic [31:0] expected_version;
    } slot_t;

    // Fields of one result transaction
    typedef struct packed {
        logic        skipped;
        logic        fill_lower;
        logic        fill_upper;
        logic        fill_right_too;
        logic        fetch;
        logic [24:0] fetch_offset;
        logic [14:0] fetch_size;
        logic        stop_channels;
        logic        start_channels;
        logic [31:0] new_version;
    } result_t;

    // Context write request from the update logic to the slot store
    typedef struct packed {
        logic  wr_en;
        slot_t data;
    } slot_wr_t;

endpackage

// ===== src/shbr_slot_state.sv =====
// Per-stream context store: one register set per stream slot.
// Depends on shbr_pkg for slot_t and slot_wr_t.
module shbr_slot_state #(
    parameter int STREAMS = shbr_pkg::STREAMS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [3:0]          stream_index,
    input  shbr_pkg::slot_wr_t  wr,
    output shbr_pkg::slot_t     rd_slot
);

    localparam int IDX_W = (STREAMS > 1) ? $clog2(STREAMS) : 1;

    shbr_pkg::slot_t slot_reg [STREAMS];

    logic [7:0]       index_ext;
    logic [IDX_W-1:0] idx;

    assign index_ext = 8'(stream_index);
    assign idx       = index_ext[IDX_W-1:0];

    // Read port for the slot addressed by the current item
    assign rd_slot = slot_reg[idx];

    // Context registers, cleared on reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STREAMS; i++)
            begin
                slot_reg[i] <= '0;
            end
        end
        else if (wr.wr_en)
        begin
            slot_reg[idx] <= wr.data;
        end
    end

endmodule

// ===== src/shbr_update.sv =====
// Single-pass decision logic: poll, start and stop handling for one slot.
// Depends on shbr_pkg for item, slot, result and write types.
module shbr_update #(
    parameter int STREAMS         = shbr_pkg::STREAMS_DEF,
    parameter int RING_SAMPLES    = shbr_pkg::RING_SAMPLES_DEF,
    parameter int READ_BYTES_MONO = shbr_pkg::READ_BYTES_MONO_DEF
) (
    input  shbr_pkg::item_t    item,
    input  shbr_pkg::slot_t    slot,
    output shbr_pkg::slot_wr_t wr,
    output shbr_pkg::result_t  res
);

    localparam int          HALF        = RING_SAMPLES / 2;
    localparam logic [16:0] HALF17      = 17'(HALF);
    localparam logic [24:0] HALF25      = 25'(HALF);
    localparam logic [26:0] HALF27      = 27'(HALF);
    localparam logic [26:0] RING27      = 27'(2 * HALF);
    localparam logic [24:0] SIZE_MONO25 = 25'(READ_BYTES_MONO);
    localparam logic [24:0] SIZE_ST25   = 25'(2 * READ_BYTES_MONO);
    localparam logic [14:0] SIZE_MONO15 = 15'(READ_BYTES_MONO);
    localparam logic [14:0] SIZE_ST15   = 15'(2 * READ_BYTES_MONO);

    logic        in_range;
    logic        skip;
    logic [16:0] pos17;
    logic [15:0] logical;
    logic [26:0] extra;
    logic        room_fill;
    logic        room_read;
    logic [24:0] p;
    logic [24:0] off;
    logic        fill;
    logic        do_fetch;

    assign in_range = 32'(item.stream_index) < 32'(STREAMS);
    assign skip     = !in_range || !slot.active
                      || (slot.expected_version != item.left_version);
    assign pos17    = 17'(item.left_pos);
    assign logical  = (pos17 > HALF17) ? 16'(pos17 - HALF17) : item.left_pos;
    assign extra    = slot.first_pending ? 27'd0 : HALF27;

    // Room left in the clip for another half and for a further read
    assign room_fill = (27'(slot.played) + HALF27 + extra) < 27'(slot.total);
    assign room_read = (27'(slot.played) + RING27 + extra) < 27'(slot.total);

    always_comb
    begin
        res      = '0;
        wr.wr_en = 1'b0;
        wr.data  = slot;
        p        = slot.played;
        off      = slot.byte_offset;
        fill     = 1'b0;
        do_fetch = 1'b0;

        unique case (item.kind)
            shbr_pkg::KIND_POLL:
            begin
                if (skip)
                begin
                    res.skipped = 1'b1;
                end
                else
                begin
                    wr.wr_en = 1'b1;
                    // Half boundary crossings
                    if ((pos17 >= HALF17) && !slot.upper_next)
                    begin
                        wr.data.upper_next = 1'b1;
                        if (room_fill)
                        begin
                            res.fill_lower = 1'b1;
                            fill           = 1'b1;
                            do_fetch       = room_read;
                        end
                        p = p + HALF25;
                    end
                    else if ((pos17 < HALF17) && slot.upper_next)
                    begin
                        wr.data.upper_next = 1'b0;
                        if (room_fill)
                        begin
                            res.fill_upper = 1'b1;
                            fill           = 1'b1;
                            do_fetch       = room_read;
                        end
                        if (slot.first_pending)
                        begin
                            wr.data.first_pending = 1'b0;
                        end
                        else
                        begin
                            p = p + HALF25;
                        end
                    end
                    if (fill)
                    begin
                        res.fill_right_too = slot.two_channel;
                    end

                    // End of clip: loop back or stop
                    if ((26'(p) + 26'(logical)) > 26'(slot.total))
                    begin
                        if (slot.loops)
                        begin
                            off = '0;
                            p   = '0;
                        end
                        else
                        begin
                            res.stop_channels = 1'b1;
                            wr.data.active    = 1'b0;
                            do_fetch          = 1'b0;
                        end
                    end
                    wr.data.played = p;

                    // Queue the next read and advance the file offset
                    if (do_fetch)
                    begin
                        res.fetch        = 1'b1;
                        res.fetch_offset = off;
                        res.fetch_size   = slot.two_channel ? SIZE_ST15 : SIZE_MONO15;
                        off = off + (slot.two_channel ? SIZE_ST25 : SIZE_MONO25);
                    end
                    wr.data.byte_offset = off;
                end
            end

            shbr_pkg::KIND_START:
            begin
                if (in_range)
                begin
                    wr.wr_en                 = 1'b1;
                    wr.data.active           = 1'b1;
                    wr.data.total            = item.total_samples_in;
                    wr.data.played           = '0;
                    wr.data.upper_next       = 1'b1;
                    wr.data.first_pending    = 1'b1;
                    wr.data.loops            = item.loop_in;
                    wr.data.two_channel      = item.stereo_in;
                    wr.data.byte_offset      = item.start_offset;
                    wr.data.expected_version = slot.expected_version + 32'd1;
                    res.start_channels       = 1'b1;
                    res.new_version          = slot.expected_version + 32'd1;
                end
            end

            shbr_pkg::KIND_STOP:
            begin
                if (in_range && slot.active)
                begin
                    wr.wr_en          = 1'b1;
                    wr.data.active    = 1'b0;
                    res.stop_channels = 1'b1;
                end
            end

            default:
            begin
                res = '0;
            end
        endcase
    end

endmodule

// ===== src/stream_half_buffer_refill.sv =====
// Top level of the stream half-buffer refill controller; uses shbr_pkg,
// shbr_slot_state and shbr_update.
// Each accepted transaction is decided and registered in the output register when that is
// free or drains; m_tready low holds it in the input register. Throughput: one item per
// cycle unless m_tready stalls; the slot context commits with the result register.
// Reset: asynchronous, active low; clears all stream contexts and both valid flags.
module stream_half_buffer_refill #(
    parameter int STREAMS         = shbr_pkg::STREAMS_DEF,
    parameter int RING_SAMPLES    = shbr_pkg::RING_SAMPLES_DEF,
    parameter int READ_BYTES_MONO = shbr_pkg::READ_BYTES_MONO_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // kind[1:0]
    input  logic [shbr_pkg::IN_USER_W-1:0]  s_tuser,
    // stream_index[3:0], left_pos[19:4], left_version[51:20],
    // total_samples_in[75:52], loop_in[76], stereo_in[77], start_offset[102:78], pad[103]
    input  logic [shbr_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // skipped[0], fill_lower[1], fill_upper[2], fill_right_too[3], fetch[4],
    // fetch_offset[29:5], fetch_size[44:30], stop_channels[45], start_channels[46],
    // new_version[78:47], pad[79]
    output logic [shbr_pkg::OUT_DATA_W-1:0] m_tdata
);

    logic               in_valid_reg;
    shbr_pkg::item_t    in_item_reg;
    logic               out_valid_reg;
    shbr_pkg::result_t  out_res_reg;

    logic               advance;
    shbr_pkg::item_t    item_in;
    shbr_pkg::slot_t    rd_slot;
    shbr_pkg::slot_wr_t upd_wr;
    shbr_pkg::slot_wr_t slot_wr;
    shbr_pkg::result_t  upd_res;

    // Unpack the incoming transaction
    assign item_in.kind             = s_tuser;
    assign item_in.stream_index     = s_tdata[3:0];
    assign item_in.left_pos         = s_tdata[19:4];
    assign item_in.left_version     = s_tdata[51:20];
    assign item_in.total_samples_in = s_tdata[75:52];
    assign item_in.loop_in          = s_tdata[76];
    assign item_in.stereo_in        = s_tdata[77];
    assign item_in.start_offset     = s_tdata[102:78];

    // Handshake: the held item moves on whenever the output register is free or drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg <= item_in;
        end
    end

    shbr_slot_state #(
        .STREAMS (STREAMS)
    ) u_slot_state (
        .clk          (clk),
        .rst_n        (rst_n),
        .stream_index (in_item_reg.stream_index),
        .wr           (slot_wr),
        .rd_slot      (rd_slot)
    );

    shbr_update #(
        .STREAMS         (STREAMS),
        .RING_SAMPLES    (RING_SAMPLES),
        .READ_BYTES_MONO (READ_BYTES_MONO)
    ) u_update (
        .item (in_item_reg),
        .slot (rd_slot),
        .wr   (upd_wr),
        .res  (upd_res)
    );

    // Context is committed only when the result is registered
    always_comb
    begin
        slot_wr       = upd_wr;
        slot_wr.wr_en = upd_wr.wr_en && advance;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= upd_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0,
                       out_res_reg.new_version,
                       out_res_reg.start_channels,
                       out_res_reg.stop_channels,
                       out_res_reg.fetch_size,
                       out_res_reg.fetch_offset,
                       out_res_reg.fetch,
                       out_res_reg.fill_right_too,
                       out_res_reg.fill_upper,
                       out_res_reg.fill_lower,
                       out_res_reg.skipped};

endmodule

// ===== src/shbr_checker.sv =====
// Port-level checks for the stream half-buffer refill controller, bound to the top level.
// Depends on shbr_pkg for the bus widths.
module shbr_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [shbr_pkg::OUT_DATA_W-1:0] m_tdata
);

    // A stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A skipped poll carries nothing else
    a_skip_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[79:1] == 79'd0)
        else $error("skipped result has other fields set");

    // A fetch only comes with a fill
    a_fetch_fill: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[4] |-> (m_tdata[1] || m_tdata[2]))
        else $error("fetch without fill");

    // Without a fetch the read offset and size are zero
    a_fetch_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[4] |-> m_tdata[44:5] == 40'd0)
        else $error("fetch fields set without fetch");

    // A start never also stops, and a start result comes only from a start item
    a_start_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[46] |-> !m_tdata[45] && m_tdata[4:0] == 5'd0)
        else $error("start result mixed with poll or stop fields");

endmodule

bind stream_half_buffer_refill shbr_checker u_shbr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for stream_half_buffer_refill: a directed table, then random start,
// stop, poll and unused-kind traffic, scored against an in-bench per-stream refill model
// (typed table rows against the table). Depends on shbr_pkg and the RTL; reads no files.
module testbench;

    localparam int              N_STREAMS    = 16;
    localparam longint unsigned HALF         = 64'd16384;
    localparam longint unsigned RING         = 64'd32768;
    localparam longint unsigned MASK25       = 64'h1FF_FFFF;
    localparam logic [14:0]     MONO_BYTES   = 15'd8192;
    localparam logic [14:0]     STEREO_BYTES = 15'd16384;
    localparam logic [1:0]      KIND_UNUSED  = 2'd3;
    localparam int              RANDOM_ITEMS = 1125;
    localparam int              HOLD_CYCLES  = 400;
    localparam int              CYCLE_LIMIT  = 200000;
    localparam int              DRAIN_CYCLES = 20;

    // Bench copy of one stream's context
    typedef struct packed {
        logic        live;
        logic [24:0] played;
        logic [23:0] total;
        logic [24:0] offset;
        logic        upper_next;
        logic        first_pending;
        logic        loops;
        logic        stereo;
        logic [31:0] version;
    } stream_ctx_t;

    // One line of the directed table; want is used only when typed is set
    typedef struct packed {
        shbr_pkg::item_t   it;
        logic              typed;
        shbr_pkg::result_t want;
    } plan_row_t;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [shbr_pkg::IN_USER_W-1:0]  s_tuser;
    logic [shbr_pkg::IN_DATA_W-1:0]  s_tdata;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [shbr_pkg::OUT_DATA_W-1:0] m_tdata;

    stream_ctx_t       ctx [N_STREAMS];
    shbr_pkg::result_t expected_results [$];
    plan_row_t         plan [$];

    int phase         = 0;
    int hold_requests = 0;
    int fail_count    = 0;
    int cycle_count   = 0;
    int checked       = 0;
    int n_directed    = 0;
    int n_random      = 0;
    int n_fill        = 0;
    int n_fetch       = 0;
    int n_stop        = 0;
    int n_skip        = 0;

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    stream_half_buffer_refill uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Refill decision for one item; updates the bench stream context
    function automatic shbr_pkg::result_t predict_refill(input shbr_pkg::item_t it);
        shbr_pkg::result_t r;
        longint unsigned   p;
        longint unsigned   t;
        longint unsigned   logical;
        longint unsigned   extra;
        longint unsigned   pos;
        logic              room_fill;
        logic              room_read;
        logic              fill;
        logic              do_fetch;
        logic [14:0]       size;
        int                s;
        r = '0;
        fill = 1'b0;
        do_fetch = 1'b0;
        s = int'(it.stream_index);
        pos = 64'(it.left_pos);
        case (it.kind)
            shbr_pkg::KIND_POLL:
            begin
                if (!ctx[s].live || ctx[s].version != it.left_version)
                begin
                    r.skipped = 1'b1;
                end
                else
                begin
                    logical = (pos > HALF) ? pos - HALF : pos;
                    p = 64'(ctx[s].played);
                    t = 64'(ctx[s].total);
                    extra = ctx[s].first_pending ? 64'd0 : HALF;
                    room_fill = (p + HALF + extra) < t;
                    room_read = (p + RING + extra) < t;
                    if (pos >= HALF && !ctx[s].upper_next)
                    begin
                        // crossed into the upper half: refill the lower one
                        ctx[s].upper_next = 1'b1;
                        if (room_fill)
                        begin
                            r.fill_lower = 1'b1;
                            fill = 1'b1;
                            do_fetch = room_read;
                        end
                        p = (p + HALF) & MASK25;
                    end
                    else if (pos < HALF && ctx[s].upper_next)
                    begin
                        // wrapped into the lower half: refill the upper one
                        ctx[s].upper_next = 1'b0;
                        if (room_fill)
                        begin
                            r.fill_upper = 1'b1;
                            fill = 1'b1;
                            do_fetch = room_read;
                        end
                        if (ctx[s].first_pending)
                            ctx[s].first_pending = 1'b0;
                        else
                            p = (p + HALF) & MASK25;
                    end
                    if (fill)
                        r.fill_right_too = ctx[s].stereo;
                    // end of clip: loop back or stop
                    if (p + logical > t)
                    begin
                        if (ctx[s].loops)
                        begin
                            ctx[s].offset = '0;
                            p = 64'd0;
                        end
                        else
                        begin
                            r.stop_channels = 1'b1;
                            ctx[s].live = 1'b0;
                            do_fetch = 1'b0;
                        end
                    end
                    ctx[s].played = 25'(p);
                    if (do_fetch)
                    begin
                        size = ctx[s].stereo ? STEREO_BYTES : MONO_BYTES;
                        r.fetch = 1'b1;
                        r.fetch_offset = ctx[s].offset;
                        r.fetch_size = size;
                        ctx[s].offset = ctx[s].offset + 25'(size);
                    end
                end
            end
            shbr_pkg::KIND_START:
            begin
                ctx[s].live = 1'b1;
                ctx[s].total = it.total_samples_in;
                ctx[s].played = '0;
                ctx[s].upper_next = 1'b1;
                ctx[s].first_pending = 1'b1;
                ctx[s].loops = it.loop_in;
                ctx[s].stereo = it.stereo_in;
                ctx[s].offset = it.start_offset;
                ctx[s].version = ctx[s].version + 32'd1;
                r.start_channels = 1'b1;
                r.new_version = ctx[s].version;
            end
            shbr_pkg::KIND_STOP:
            begin
                if (ctx[s].live)
                begin
                    ctx[s].live = 1'b0;
                    r.stop_channels = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic plan_row_t plan_row(input logic [1:0] kind, input logic [3:0] idx,
                                           input logic [15:0] pos, input logic [31:0] ver,
                                           input logic [23:0] total, input logic lp,
                                           input logic st, input logic [24:0] off,
                                           input logic typed, input logic skip,
                                           input logic stop, input logic start,
                                           input logic [31:0] nver);
        plan_row_t r;
        r.it.kind = kind;
        r.it.stream_index = idx;
        r.it.left_pos = pos;
        r.it.left_version = ver;
        r.it.total_samples_in = total;
        r.it.loop_in = lp;
        r.it.stereo_in = st;
        r.it.start_offset = off;
        r.typed = typed;
        r.want = '0;
        r.want.skipped = skip;
        r.want.stop_channels = stop;
        r.want.start_channels = start;
        r.want.new_version = nver;
        return r;
    endfunction

    task automatic queue_expected(input shbr_pkg::result_t want);
        expected_results.push_back(want);
        if (want.fill_lower || want.fill_upper)
            n_fill++;
        if (want.fetch)
            n_fetch++;
        if (want.stop_channels)
            n_stop++;
        if (want.skipped)
            n_skip++;
    endtask

    // Present one transaction at the falling edge and hold it until accepted
    task automatic offer(input shbr_pkg::item_t it);
        @(negedge clk);
        while ((phase == 1 && $urandom_range(99) < 66) || (phase == 3 && $urandom_range(99) < 38))
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.kind;
        s_tdata <= {1'b0, it.start_offset, it.stereo_in, it.loop_in, it.total_samples_in,
                    it.left_version, it.left_pos, it.stream_index};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Stimulus
    initial
    begin
        shbr_pkg::item_t   it;
        shbr_pkg::result_t want;
        int                i;
        int                s;
        int                roll;
        int                live_list [$];
        for (i = 0; i < N_STREAMS; i++)
            ctx[i] = '0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = '0;
        s_tdata = '0;

        // kind, slot, pos, version, total, loop, stereo, offset, typed, skip, stop, start, ver
        // poll after reset, stop on idle, unknown kind with every field but the slot all ones
        plan.push_back(plan_row(shbr_pkg::KIND_POLL, 4'd0, 16'h0000, 32'h0000_0000,
                                24'h00_0000, 1'b0, 1'b0, 25'h000_0000,
                                1'b1, 1'b1, 1'b0, 1'b0, 32'd0));
        plan.push_back(plan_row(shbr_pkg::KIND_STOP, 4'd1, 16'h0000, 32'h0000_0000,
                                24'h00_0000, 1'b0, 1'b0, 25'h000_0000,
                                1'b1, 1'b0, 1'b0, 1'b0, 32'd0));
        plan.push_back(plan_row(KIND_UNUSED, 4'd2, 16'hFFFF, 32'hFFFF_FFFF,
                                24'hFF_FFFF, 1'b1, 1'b1, 25'h1FF_FFFF,
                                1'b1, 1'b0, 1'b0, 1'b0, 32'd0));
        // longest stereo loop, offset close to the top so the fetch offset wraps
        plan.push_back(plan_row(shbr_pkg::KIND_START, 4'd0, 16'h0000, 32'h0000_0000,
                                24'hFF_FFFF, 1'b1, 1'b1, 25'h1FF_C000,
                                1'b1, 1'b0, 1'b0, 1'b1, 32'd1));
        plan.push_back(plan_row(shbr_pkg::KIND_POLL, 4'd0, 16'h0000, 32'h0000_0001,
                                24'h00_0000, 1'b0, 1'b0, 25'h000_0000,
                                1'b0, 1'b0, 1'b0, 1'b0, 32'd0));
        plan.push_back(plan_row(shbr_pkg::KIND_POLL, 4'd0, 16'hFFFF, 32'h0000_0001,
                                24'h00_0000, 1'b0, 1'b0, 25'h000_0000,
                                1'b0, 1'b0, 1'b0, 1'b0, 32'd0));
        plan.push_back(plan_row(shbr_pkg::KIND_POLL, 4'd0, 16'h4000, 32'h0000_0001,
                                24'h00_0000, 1'b0, 1'b0, 25'h000_0000,
                                1'b0, 1'b0, 1'b0, 1'b0, 32'd0));
        plan.push_back(plan_row(shbr_pkg::KIND_POLL, 4'd0, 16'h3FFF, 32'h0000_0001,
                                24'h00_0000, 1'b0, 1'b0, 25'h000_0000,
                                1'b0, 1'b0, 1'b0, 1'b0, 32'd0));
        // stale version
        plan.push_back(plan_row(shbr_pkg::KIND_POLL, 4'd0, 16'h0000, 32'hFFFF_FFFF,
                                24'h00_0000, 1'b0, 1'b0, 25'h000_0000,
                                1'b1, 1'b1, 1'b0, 1'b0, 32'd0));
        // re-arm an active stream; the second poll ends the clip with a fetch held back
        plan.push_back(plan_row(shbr_pkg::KIND_START, 4'd0, 16'h0000, 32'h0000_0000,
                                24'h00_EA60, 1'b0, 1'b0, 25'h000_0000,
                                1'b1, 1'b0, 1'b0, 1'b1, 32'd2));
        plan.push_back(plan_row(shbr_pkg::KIND_POLL, 4'd0, 16'h0000, 32'h0000_0002,
                                24'h00_0000, 1'b0, 1'b0, 25'h000_0000,
                                1'b0, 1'b0, 1'b0, 1'b0, 32'd0));
        plan.push_back(plan_row(shbr_pkg::KIND_POLL, 4'd0, 16'hFFFF, 32'h0000_0002,
                                24'h00_0000, 1'b0, 1'b0, 25'h000_0000,
                                1'b0, 1'b0, 1'b0, 1'b0, 32'd0));
        plan.push_back(plan_row(shbr_pkg::KIND_POLL, 4'd0, 16'h0000, 32'h0000_0002,
                                24'h00_0000, 1'b0, 1'b0, 25'h000_0000,
                                1'b1, 1'b1, 1'b0, 1'b0, 32'd0));
        // empty looping clip on the top slot, then stop it twice
        plan.push_back(plan_row(shbr_pkg::KIND_START, 4'd15, 16'h0000, 32'h0000_0000,
                                24'h00_0000, 1'b1, 1'b0, 25'h1FF_FFFF,
                                1'b1, 1'b0, 1'b0, 1'b1, 32'd1));
        plan.push_back(plan_row(shbr_pkg::KIND_POLL, 4'd15, 16'h8000, 32'h0000_0001,
                                24'h00_0000, 1'b0, 1'b0, 25'h000_0000,
                                1'b0, 1'b0, 1'b0, 1'b0, 32'd0));
        plan.push_back(plan_row(shbr_pkg::KIND_POLL, 4'd15, 16'h0000, 32'h0000_0001,
                                24'h00_0000, 1'b0, 1'b0, 25'h000_0000,
                                1'b0, 1'b0, 1'b0, 1'b0, 32'd0));
        plan.push_back(plan_row(shbr_pkg::KIND_STOP, 4'd15, 16'h0000, 32'h0000_0000,
                                24'h00_0000, 1'b0, 1'b0, 25'h000_0000,
                                1'b1, 1'b0, 1'b1, 1'b0, 32'd0));
        plan.push_back(plan_row(shbr_pkg::KIND_STOP, 4'd15, 16'h0000, 32'h0000_0000,
                                24'h00_0000, 1'b0, 1'b0, 25'h000_0000,
                                1'b1, 1'b0, 1'b0, 1'b0, 32'd0));
        // short stereo loop
        plan.push_back(plan_row(shbr_pkg::KIND_START, 4'd7, 16'h0000, 32'h0000_0000,
                                24'h00_7530, 1'b1, 1'b1, 25'h000_1000,
                                1'b1, 1'b0, 1'b0, 1'b1, 32'd1));
        plan.push_back(plan_row(shbr_pkg::KIND_POLL, 4'd7, 16'h0000, 32'h0000_0001,
                                24'h00_0000, 1'b0, 1'b0, 25'h000_0000,
                                1'b0, 1'b0, 1'b0, 1'b0, 32'd0));
        plan.push_back(plan_row(shbr_pkg::KIND_POLL, 4'd7, 16'hC000, 32'h0000_0001,
                                24'h00_0000, 1'b0, 1'b0, 25'h000_0000,
                                1'b0, 1'b0, 1'b0, 1'b0, 32'd0));
        plan.push_back(plan_row(shbr_pkg::KIND_POLL, 4'd7, 16'h0000, 32'h0000_0001,
                                24'h00_0000, 1'b0, 1'b0, 25'h000_0000,
                                1'b0, 1'b0, 1'b0, 1'b0, 32'd0));
        plan.push_back(plan_row(shbr_pkg::KIND_POLL, 4'd7, 16'h8001, 32'h0000_0001,
                                24'h00_0000, 1'b0, 1'b0, 25'h000_0000,
                                1'b0, 1'b0, 1'b0, 1'b0, 32'd0));
        plan.push_back(plan_row(KIND_UNUSED, 4'd15, 16'h0000, 32'h0000_0000,
                                24'h00_0000, 1'b0, 1'b0, 25'h000_0000,
                                1'b1, 1'b0, 1'b0, 1'b0, 32'd0));
        plan.push_back(plan_row(shbr_pkg::KIND_POLL, 4'd7, 16'hFFFF, 32'h0000_0001,
                                24'h00_0000, 1'b0, 1'b0, 25'h000_0000,
                                1'b0, 1'b0, 1'b0, 1'b0, 32'd0));

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table
        foreach (plan[k])
        begin
            want = predict_refill(plan[k].it);
            if (plan[k].typed)
                want = plan[k].want;
            queue_expected(want);
            offer(plan[k].it);
            n_directed++;
        end

        // Random traffic; the first transactions run against a long output hold
        hold_requests++;
        while (n_random < RANDOM_ITEMS)
        begin
            phase = (n_random * 4) / RANDOM_ITEMS;
            live_list.delete();
            for (i = 0; i < N_STREAMS; i++)
                if (ctx[i].live)
                    live_list.push_back(i);

            // every field random first, then shaped by kind
            it.kind = shbr_pkg::KIND_POLL;
            it.stream_index = 4'($urandom_range(N_STREAMS - 1));
            it.left_pos = 16'($urandom);
            it.left_version = $urandom;
            it.total_samples_in = 24'($urandom);
            it.loop_in = 1'($urandom);
            it.stereo_in = 1'($urandom);
            it.start_offset = 25'($urandom);
            if (live_list.size() != 0 && $urandom_range(99) < 90)
                it.stream_index = 4'(live_list[$urandom_range(live_list.size() - 1)]);
            s = int'(it.stream_index);

            roll = $urandom_range(99);
            if (roll < 10)
            begin
                it.kind = shbr_pkg::KIND_START;
                it.stream_index = 4'($urandom_range(N_STREAMS - 1));
                roll = $urandom_range(99);
                if (roll < 10)
                    it.total_samples_in = 24'($urandom_range(20000));
                else if (roll < 80)
                    it.total_samples_in = 24'($urandom_range(150000));
                if ($urandom_range(9) == 0)
                    it.start_offset = 25'h1FF_FFFF - 25'($urandom_range(40000));
            end
            else if (roll < 15)
            begin
                it.kind = shbr_pkg::KIND_STOP;
            end
            else if (roll < 18)
            begin
                it.kind = KIND_UNUSED;
            end
            else
            begin
                if ($urandom_range(99) < 92)
                    it.left_version = ctx[s].version;
                roll = $urandom_range(99);
                if (roll < 80)
                    it.left_pos = ctx[s].upper_next ? 16'($urandom_range(16383))
                                                    : 16'($urandom_range(65535, 16384));
                else if (roll < 90)
                begin
                    case ($urandom_range(4))
                        0: it.left_pos = 16'h3FFF;
                        1: it.left_pos = 16'h4000;
                        2: it.left_pos = 16'h4001;
                        3: it.left_pos = 16'h0000;
                        default: it.left_pos = 16'hFFFF;
                    endcase
                end
            end

            want = predict_refill(it);
            queue_expected(want);
            offer(it);
            n_random++;
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        phase = 0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d directed + %0d random transactions; four stall phases, one long hold",
                 n_directed, n_random);
        $display("%0d results checked (%0d fills, %0d fetches, %0d stops, %0d skips)",
                 checked, n_fill, n_fetch, n_stop, n_skip);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Output ready: random stalls per phase, plus the requested long hold
    initial
    begin
        int hold_left;
        int holds_served;
        hold_left = 0;
        holds_served = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_served != hold_requests)
            begin
                holds_served = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (phase == 2)
                m_tready <= ($urandom_range(99) >= 66);
            else if (phase == 3)
                m_tready <= ($urandom_range(99) >= 38);
            else
                m_tready <= 1'b1;
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        shbr_pkg::result_t got;
        shbr_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.skipped        = m_tdata[0];
            got.fill_lower     = m_tdata[1];
            got.fill_upper     = m_tdata[2];
            got.fill_right_too = m_tdata[3];
            got.fetch          = m_tdata[4];
            got.fetch_offset   = m_tdata[29:5];
            got.fetch_size     = m_tdata[44:30];
            got.stop_channels  = m_tdata[45];
            got.start_channels = m_tdata[46];
            got.new_version    = m_tdata[78:47];
            if (expected_results.size() == 0)
            begin
                $error("result transaction with nothing expected");
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                checked++;
                if (got.skipped != want.skipped)
                begin
                    $error("skipped: expected %0d, got %0d", want.skipped, got.skipped);
                    fail_count++;
                end
                if (got.fill_lower != want.fill_lower)
                begin
                    $error("fill_lower: expected %0d, got %0d", want.fill_lower, got.fill_lower);
                    fail_count++;
                end
                if (got.fill_upper != want.fill_upper)
                begin
                    $error("fill_upper: expected %0d, got %0d", want.fill_upper, got.fill_upper);
                    fail_count++;
                end
                if (got.fill_right_too != want.fill_right_too)
                begin
                    $error("fill_right_too: expected %0d, got %0d",
                           want.fill_right_too, got.fill_right_too);
                    fail_count++;
                end
                if (got.fetch != want.fetch)
                begin
                    $error("fetch: expected %0d, got %0d", want.fetch, got.fetch);
                    fail_count++;
                end
                if (got.fetch_offset != want.fetch_offset)
                begin
                    $error("fetch_offset: expected 0x%0h, got 0x%0h",
                           want.fetch_offset, got.fetch_offset);
                    fail_count++;
                end
                if (got.fetch_size != want.fetch_size)
                begin
                    $error("fetch_size: expected %0d, got %0d", want.fetch_size, got.fetch_size);
                    fail_count++;
                end
                if (got.stop_channels != want.stop_channels)
                begin
                    $error("stop_channels: expected %0d, got %0d",
                           want.stop_channels, got.stop_channels);
                    fail_count++;
                end
                if (got.start_channels != want.start_channels)
                begin
                    $error("start_channels: expected %0d, got %0d",
                           want.start_channels, got.start_channels);
                    fail_count++;
                end
                if (got.new_version != want.new_version)
                begin
                    $error("new_version: expected 0x%0h, got 0x%0h",
                           want.new_version, got.new_version);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

endmodule
